@@ hw/rtl/smoothed_fractional_predelay_unit_defines.svh @@
// Assertion macros shared by the top, ring and ramp RTL files
`ifndef SMOOTHED_FRACTIONAL_PREDELAY_UNIT_DEFINES_SVH
`define SMOOTHED_FRACTIONAL_PREDELAY_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SFPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfpd assertion failed");

// Next-cycle implication, checked outside reset
`define SFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfpd assertion failed");

`endif

@@ hw/rtl/sfpd_pkg.sv @@
// Package: constants, types and helpers of the smoothed fractional predelay
package sfpd_pkg;

    localparam int BUFFER_DEPTH  = 32768;          // power of two
    localparam int ADDR_BITS     = $clog2(BUFFER_DEPTH);
    localparam int SAMPLE_BITS   = 24;
    localparam int FRACTION_BITS = 12;
    localparam int ACC_EXTRA     = 13;
    localparam int TARGET_BITS   = 27;
    localparam int RAMP_BITS     = 16;
    localparam int DELAY_BITS    = TARGET_BITS + ACC_EXTRA;
    localparam int INC_BITS      = DELAY_BITS + 1;
    localparam int INT_BITS      = TARGET_BITS - FRACTION_BITS;
    // Horner accumulator: |a| stays below 23 * 2^(SAMPLE_BITS-1)
    localparam int ACC_BITS      = SAMPLE_BITS + 5;
    localparam int PROD_BITS     = ACC_BITS + FRACTION_BITS + 1;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = TARGET_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_DELAY = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP_LENGTH  = CFG_INDEX_BITS'(1);

    localparam logic [RAMP_BITS-1:0] RAMP_RESET = RAMP_BITS'(2400);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef logic [ADDR_BITS-1:0]          addr_t;
    typedef logic [FRACTION_BITS-1:0]      frac_t;
    typedef logic [DELAY_BITS-1:0]         delay_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } frame_t;

    // Four taps, farthest (y3) first down to nearest (y0)
    typedef struct packed {
        sample_t y3;
        sample_t y2;
        sample_t y1;
        sample_t y0;
    } taps_t;

    // Delay status handed from the smoother to the sequencer
    typedef struct packed {
        logic  busy;
        addr_t ip;
        frac_t frac;
    } delay_status_t;

    localparam acc_t SAT_HI =
        acc_t'({{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
    localparam acc_t SAT_LO =
        acc_t'({{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}});

    function automatic acc_t sx(input sample_t v);
        return acc_t'(v);
    endfunction

endpackage

@@ hw/rtl/sfpd_if.sv @@
// Handshake interfaces: input frames, output frames and configuration writes
interface sfpd_in_if import sfpd_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t in_left;
    sample_t in_right;
    modport source (output valid, output in_left, output in_right, input ready);
    modport sink (input valid, input in_left, input in_right, output ready);
endinterface

interface sfpd_out_if import sfpd_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t out_left;
    sample_t out_right;
    modport source (output valid, output out_left, output out_right, input ready);
    modport sink (input valid, input out_left, input out_right, output ready);
endinterface

interface sfpd_cfg_if import sfpd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/smoothed_fractional_predelay_unit.sv @@
// Smoothed fractional predelay: sequencer around the ring, smoother and interpolators
// One frame in flight; each runs: accept, four tap reads through the single ring read port,
//   interpolator load, Horner steps and rounding, output hand-off.
// A configuration write starting a ramp holds cfg.ready low while the divider runs,
//   and the input also while the divider quotient is loaded.
// Reset: async active low; the ring reads as zero until written (fill tracking).
`include "smoothed_fractional_predelay_unit_defines.svh"

module smoothed_fractional_predelay_unit import sfpd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    sfpd_in_if.sink     src,
    sfpd_out_if.source  dst,
    sfpd_cfg_if.sink    cfg
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] tap_cnt_reg;
    logic [1:0] tap_cnt_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    addr_t      base_reg;
    frac_t      frac_reg;
    frame_t     y_reg [3];
    sample_t    out_left_reg;
    sample_t    out_right_reg;

    delay_status_t dly;
    logic          in_fire;
    logic          out_free;
    logic          load_out;
    addr_t         wr_index;
    addr_t         rd_addr;
    logic          rd_en;
    frame_t        rd_data;
    taps_t         taps_l;
    taps_t         taps_r;
    logic          done_l;
    logic          done_r;
    sample_t       res_l;
    sample_t       res_r;

    assign src.ready = (state_reg == S_IDLE) && !dly.busy;
    assign in_fire   = src.valid && src.ready;
    assign out_free  = !out_valid_reg || dst.ready;
    assign load_out  = (state_reg == S_FIN) && out_free;
    assign rd_en     = (state_reg == S_READ);
    assign rd_addr   = base_reg - addr_t'(tap_cnt_reg);

    sfpd_ramp u_ramp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (in_fire),
        .status (dly)
    );

    sfpd_ring u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_fire),
        .wr_data  ({src.in_left, src.in_right}),
        .wr_index (wr_index),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // Farthest tap comes straight from the registered read port output in S_LAST
    assign taps_l = '{y3: rd_data.left, y2: y_reg[2].left,
                      y1: y_reg[1].left, y0: y_reg[0].left};
    assign taps_r = '{y3: rd_data.right, y2: y_reg[2].right,
                      y1: y_reg[1].right, y0: y_reg[0].right};

    sfpd_interp u_interp_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == S_LAST),
        .taps   (taps_l),
        .frac   (frac_reg),
        .done   (done_l),
        .result (res_l)
    );

    sfpd_interp u_interp_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == S_LAST),
        .taps   (taps_r),
        .frac   (frac_reg),
        .done   (done_r),
        .result (res_r)
    );

    // Frame sequencer
    always_comb
    begin
        state_next     = state_reg;
        tap_cnt_next   = tap_cnt_reg;
        out_valid_next = out_valid_reg;
        if (dst.valid && dst.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next   = S_READ;
                    tap_cnt_next = 2'd0;
                end
            end
            S_READ:
            begin
                tap_cnt_next = tap_cnt_reg + 2'd1;
                if (tap_cnt_reg == 2'd3)
                    state_next = S_LAST;
            end
            S_LAST:
                state_next = S_CALC;
            S_CALC:
            begin
                if (done_l && done_r)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tap_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_cnt_reg   <= tap_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Tap addressing, tap capture and output register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            base_reg <= wr_index - dly.ip + addr_t'(1);
            frac_reg <= dly.frac;
        end
        if ((state_reg == S_READ) && (tap_cnt_reg != 2'd0))
            y_reg[tap_cnt_reg - 2'd1] <= rd_data;
        if (load_out)
        begin
            out_left_reg  <= res_l;
            out_right_reg <= res_r;
        end
    end

    assign dst.valid     = out_valid_reg;
    assign dst.out_left  = out_left_reg;
    assign dst.out_right = out_right_reg;

    `SFPD_ASSERT_NEXT(a_top_accept_starts, clk, rst_n, in_fire, (state_reg == S_READ) && (tap_cnt_reg == 2'd0))
    `SFPD_ASSERT_IMP(a_top_done_in_calc, clk, rst_n, done_l || done_r, (state_reg == S_CALC) && done_l && done_r)
    `SFPD_ASSERT_NEXT(a_top_result_shown, clk, rst_n, load_out, dst.valid && (state_reg == S_IDLE))

endmodule

@@ hw/rtl/sfpd_ring.sv @@
// Stereo ring buffer: one write port, one registered read port, fill tracking
`include "smoothed_fractional_predelay_unit_defines.svh"

module sfpd_ring import sfpd_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  frame_t wr_data,
    output addr_t  wr_index,
    input  logic   rd_en,
    input  addr_t  rd_addr,
    output frame_t rd_data
);

    logic [$bits(frame_t)-1:0] mem [BUFFER_DEPTH];

    addr_t  widx_reg;
    addr_t  widx_next;
    logic   wrapped_reg;
    logic   wrapped_next;
    frame_t rd_q_reg;
    logic   rd_ok_reg;

    // Write pointer and wrap flag: entries not yet written read as zero
    always_comb
    begin
        widx_next    = widx_reg;
        wrapped_next = wrapped_reg;
        if (wr_en)
        begin
            widx_next = widx_reg + addr_t'(1);
            if (widx_reg == addr_t'(BUFFER_DEPTH - 1))
                wrapped_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg    <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            widx_reg    <= widx_next;
            wrapped_reg <= wrapped_next;
        end
    end

    // Memory array
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[widx_reg] <= wr_data;
        if (rd_en)
        begin
            rd_q_reg  <= mem[rd_addr];
            rd_ok_reg <= wrapped_reg || (rd_addr < widx_reg);
        end
    end

    assign wr_index = widx_reg;
    assign rd_data  = rd_ok_reg ? rd_q_reg : '0;

    `SFPD_ASSERT_IMP(a_ring_no_collide, clk, rst_n, wr_en, !rd_en)
    `SFPD_ASSERT_NEXT(a_ring_wrap, clk, rst_n, wr_en && (widx_reg == addr_t'(BUFFER_DEPTH - 1)), wrapped_reg)
    `SFPD_ASSERT_NEXT(a_ring_unwritten, clk, rst_n, rd_en && !wrapped_reg && (rd_addr >= widx_reg), rd_data == '0)

endmodule

@@ hw/rtl/sfpd_ramp_div.sv @@
// Restoring divider, one quotient bit per cycle, for the ramp increment
module sfpd_ramp_div import sfpd_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  delay_t                     dividend,
    input  logic [RAMP_BITS-1:0]       divisor,
    input  logic                       negate,
    output logic                       busy,
    output logic                       done,
    output logic signed [INC_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(DELAY_BITS + 1);

    delay_t               quo_reg;
    delay_t               quo_next;
    logic [RAMP_BITS-1:0] rem_reg;
    logic [RAMP_BITS-1:0] rem_next;
    logic [RAMP_BITS-1:0] dvs_reg;
    logic                 neg_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [CNT_BITS-1:0]  cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;

    logic [RAMP_BITS:0] rem_shift;
    logic [RAMP_BITS:0] rem_sub;
    logic               ge;

    // One shift-subtract step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DELAY_BITS-1]};
        ge        = rem_shift >= {1'b0, dvs_reg};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(DELAY_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DELAY_BITS-2:0], ge};
            rem_next = ge ? rem_sub[RAMP_BITS-1:0] : rem_shift[RAMP_BITS-1:0];
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
            neg_reg <= negate;
        end
    end

    // Truncation toward zero: divide magnitudes, then restore the sign
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

@@ hw/rtl/sfpd_ramp.sv @@
// Delay smoother: configuration registers, linear ramp and step divider
`include "smoothed_fractional_predelay_unit_defines.svh"

module sfpd_ramp import sfpd_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    sfpd_cfg_if.sink       cfg,
    input  logic           step,
    output delay_status_t  status
);

    logic [TARGET_BITS-1:0]      target_reg;
    logic [TARGET_BITS-1:0]      target_next;
    logic [RAMP_BITS-1:0]        length_reg;
    logic [RAMP_BITS-1:0]        length_next;
    delay_t                      cur_reg;
    delay_t                      cur_next;
    logic signed [INC_BITS-1:0]  inc_reg;
    logic signed [INC_BITS-1:0]  inc_next;
    logic [RAMP_BITS-1:0]        rem_reg;
    logic [RAMP_BITS-1:0]        rem_next;

    logic                        cfg_fire;
    logic                        cfg_known;
    logic [TARGET_BITS-1:0]      target_new;
    logic [RAMP_BITS-1:0]        length_new;
    delay_t                      goal_cur;
    delay_t                      goal_new;
    logic signed [INC_BITS-1:0]  diff;
    delay_t                      diff_mag;
    logic signed [INC_BITS-1:0]  cur_sum;
    delay_t                      cur_adv;
    logic [TARGET_BITS-1:0]      q;

    logic                        div_start;
    logic                        div_busy;
    logic                        div_done;
    logic signed [INC_BITS-1:0]  div_quo;

    assign cfg.ready = !div_busy;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign cfg_known = (cfg.index == REG_TARGET_DELAY) || (cfg.index == REG_RAMP_LENGTH);

    // Values after the write under way, used to restart the ramp
    assign target_new = (cfg.index == REG_TARGET_DELAY) ? cfg.data : target_reg;
    assign length_new = (cfg.index == REG_RAMP_LENGTH) ? cfg.data[RAMP_BITS-1:0] : length_reg;
    assign goal_cur   = {target_reg, {ACC_EXTRA{1'b0}}};
    assign goal_new   = {target_new, {ACC_EXTRA{1'b0}}};
    assign diff       = $signed({1'b0, goal_new}) - $signed({1'b0, cur_reg});
    assign diff_mag   = diff[INC_BITS-1] ? delay_t'(-diff) : delay_t'(diff);
    assign div_start  = cfg_fire && cfg_known && (length_new != '0);

    sfpd_ramp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_mag),
        .divisor  (length_new),
        .negate   (diff[INC_BITS-1]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Delay after this frame's advance; the last ramp frame lands on target
    assign cur_sum = $signed({1'b0, cur_reg}) + inc_reg;
    always_comb
    begin
        if (rem_reg == '0)
            cur_adv = cur_reg;
        else if (rem_reg == RAMP_BITS'(1))
            cur_adv = goal_cur;
        else
            cur_adv = cur_sum[DELAY_BITS-1:0];
    end

    // Frames wait while the divider runs and in the cycle its quotient is loaded
    assign q      = cur_adv[DELAY_BITS-1:ACC_EXTRA];
    assign status = '{busy: div_busy || div_done,
                      ip:   addr_t'(q[TARGET_BITS-1:FRACTION_BITS]),
                      frac: q[FRACTION_BITS-1:0]};

    // Register updates: frame step, divider result, then configuration
    always_comb
    begin
        target_next = target_reg;
        length_next = length_reg;
        cur_next    = cur_reg;
        inc_next    = inc_reg;
        rem_next    = rem_reg;
        if (step && (rem_reg != '0))
        begin
            cur_next = cur_adv;
            rem_next = rem_reg - RAMP_BITS'(1);
        end
        if (div_done)
            inc_next = div_quo;
        if (cfg_fire && cfg_known)
        begin
            target_next = target_new;
            length_next = length_new;
            if (length_new == '0)
            begin
                cur_next = goal_new;
                inc_next = '0;
                rem_next = '0;
            end
            else
                rem_next = length_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            length_reg <= RAMP_RESET;
            cur_reg    <= '0;
            inc_reg    <= '0;
            rem_reg    <= '0;
        end
        else
        begin
            target_reg <= target_next;
            length_reg <= length_next;
            cur_reg    <= cur_next;
            inc_reg    <= inc_next;
            rem_reg    <= rem_next;
        end
    end

    `SFPD_ASSERT_IMP(a_ramp_no_step_in_div, clk, rst_n, step, !div_busy)
    `SFPD_ASSERT_NEXT(a_ramp_lands, clk, rst_n, step && !cfg_fire && (rem_reg == RAMP_BITS'(1)), (cur_reg[ACC_EXTRA-1:0] == '0) && (cur_reg[DELAY_BITS-1:ACC_EXTRA] == target_reg))
    `SFPD_ASSERT_NEXT(a_ramp_jump, clk, rst_n, cfg_fire && (cfg.index == REG_RAMP_LENGTH) && (cfg.data[RAMP_BITS-1:0] == '0), (rem_reg == '0) && (inc_reg == '0))

endmodule

@@ hw/rtl/sfpd_interp.sv @@
// Four-point Hermite interpolator for one channel, Horner form, one step a cycle
module sfpd_interp import sfpd_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  taps_t   taps,
    input  frac_t   frac,
    output logic    done,
    output sample_t result
);

    localparam logic signed [PROD_BITS-1:0] HALF_P =
        PROD_BITS'(1) << (FRACTION_BITS - 1);

    acc_t       k0_reg;
    acc_t       k1_reg;
    acc_t       k2_reg;
    acc_t       a_reg;
    acc_t       a_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       busy_reg;
    logic       busy_next;
    logic       done_reg;
    logic       done_next;
    sample_t    res_reg;

    acc_t                        e0;
    acc_t                        e1;
    acc_t                        e2;
    acc_t                        e3;
    acc_t                        d12;
    acc_t                        k0;
    acc_t                        k1;
    acc_t                        k2;
    acc_t                        k3;
    acc_t                        k_sel;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [PROD_BITS-1:0] prod_rnd;
    logic signed [PROD_BITS-1:0] shifted;
    acc_t                        a_step;
    acc_t                        r;

    // Doubled coefficients
    always_comb
    begin
        e0  = sx(taps.y0);
        e1  = sx(taps.y1);
        e2  = sx(taps.y2);
        e3  = sx(taps.y3);
        d12 = e1 - e2;
        k0  = e1 <<< 1;
        k1  = e2 - e0;
        k2  = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        k3  = (e3 - e0) + d12 + (d12 <<< 1);
    end

    // One Horner step: floor((a*f + half) / 2^F) + next coefficient
    always_comb
    begin
        case (cnt_reg)
            2'd3:    k_sel = k2_reg;
            2'd2:    k_sel = k1_reg;
            default: k_sel = k0_reg;
        endcase
        prod     = a_reg * $signed({1'b0, frac});
        prod_rnd = prod + HALF_P;
        shifted  = prod_rnd >>> FRACTION_BITS;
        a_step   = $signed(shifted[ACC_BITS-1:0]) + k_sel;
        r        = (a_reg + acc_t'(1)) >>> 1;
    end

    always_comb
    begin
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = k3;
            cnt_next  = 2'd3;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 2'd0)
            begin
                a_next   = a_step;
                cnt_next = cnt_reg - 2'd1;
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Coefficients, accumulator and saturated result
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        if (start)
        begin
            k0_reg <= k0;
            k1_reg <= k1;
            k2_reg <= k2;
        end
        if (busy_reg && (cnt_reg == 2'd0))
        begin
            if (r > SAT_HI)
                res_reg <= SAT_HI[SAMPLE_BITS-1:0];
            else if (r < SAT_LO)
                res_reg <= SAT_LO[SAMPLE_BITS-1:0];
            else
                res_reg <= r[SAMPLE_BITS-1:0];
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
